@@ rtl/core/pswd_pkg.sv @@
// Shared sizes, control/status structs and ring helpers for the
// per-source failure window detector. No dependencies.
package pswd_pkg;

   localparam int SOURCE_ENTRIES   = 16;
   localparam int TIMES_PER_SOURCE = 16;

   localparam int ENTRY_W = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
   localparam int POS_W   = (TIMES_PER_SOURCE > 1) ? $clog2(TIMES_PER_SOURCE) : 1;
   localparam int CNT_W   = $clog2(TIMES_PER_SOURCE + 1);
   localparam int SLOTS   = SOURCE_ENTRIES * TIMES_PER_SOURCE;
   localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int THR_W   = 5;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 32;
   localparam int CNT_OUT_W = 5;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 5'd5;
   localparam logic [TIME_W-1:0] WINDOW_RESET    = 32'd300;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_WINDOW    = 1'b1;

   typedef struct packed {
      logic load;
      logic search;
      logic pick;
      logic prune;
      logic commit;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_failure;
      logic scan_last;
      logic prune_done;
   } dp_status_type;

   function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] p);
      return (p == '0) ? POS_W'(TIMES_PER_SOURCE - 1) : POS_W'(p - 1'b1);
   endfunction

   function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
      return (int'(p) == TIMES_PER_SOURCE - 1) ? '0 : POS_W'(p + 1'b1);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_of(input logic [ENTRY_W-1:0] e,
                                                 input logic [POS_W-1:0] p);
      return ADDR_W'(int'(e) * TIMES_PER_SOURCE + int'(p));
   endfunction

endpackage

@@ rtl/core/pswd_ctrl.sv @@
// Sequencing state machine of the detector: handshakes and step order.
// Depends on pswd_pkg.
module pswd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pswd_pkg::dp_status_type status,
   output pswd_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEARCH = 7'b0000010,
      S_PICK   = 7'b0000100,
      S_PRUNE  = 7'b0001000,
      S_COMMIT = 7'b0010000,
      S_OUT    = 7'b0100000,
      S_WAIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // route failures through the table, answer others at once
            state_in = status.is_failure ? S_SEARCH : S_OUT;
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (status.scan_last) state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_PRUNE;
         end
         S_PRUNE: begin
            cmd.prune = 1'b1;
            if (status.prune_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/pswd_datapath.sv @@
// Datapath of the detector: source table, time memory, prune engine,
// configuration registers and result registers. Depends on pswd_pkg.
module pswd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [pswd_pkg::CFG_W-1:0]          csr_write_data,
   input  logic [31:0]                         req_source_address,
   input  logic [31:0]                         req_event_time,
   input  logic                                req_is_failure,
   input  pswd_pkg::ctrl_cmd_type              cmd,
   output pswd_pkg::dp_status_type             status,
   output logic                                rsp_alarm,
   output logic [pswd_pkg::CNT_OUT_W-1:0]      rsp_retained_count,
   output logic                                rsp_entry_evicted
);

   localparam int E  = pswd_pkg::SOURCE_ENTRIES;
   localparam int EW = pswd_pkg::ENTRY_W;
   localparam int PW = pswd_pkg::POS_W;
   localparam int CW = pswd_pkg::CNT_W;
   localparam int AW = pswd_pkg::ADDR_W;
   localparam int TW = pswd_pkg::TIME_W;
   localparam int OW = pswd_pkg::CNT_OUT_W;

   // configuration
   logic [pswd_pkg::THR_W-1:0] thr_ff;
   logic [TW-1:0]              win_ff;

   // source table
   logic [31:0]   key_ff  [E];
   logic [TW-1:0] last_ff [E];
   logic [E-1:0]  valid_ff;
   logic [PW-1:0] head_ff [E];
   logic [CW-1:0] count_ff[E];

   // captured event
   logic [31:0]   addr_ff;
   logic [TW-1:0] now_ff;
   logic          fail_ff;

   // search results
   logic [EW-1:0] idx_ff, hit_idx_ff, free_idx_ff, min_idx_ff, ent_ff;
   logic          hit_ff, free_ff, ev_ff;
   logic [TW-1:0] min_t_ff;

   // prune engine
   logic [PW-1:0] hd_ff, rp_ff, wp_ff;
   logic [CW-1:0] rem_ff, k_ff;
   logic          rdpend_ff;
   logic [TW-1:0] rdata_ff;

   // result and output registers
   logic          res_alarm_ff, res_ev_ff;
   logic [OW-1:0] res_cnt_ff;
   logic          out_alarm_ff, out_ev_ff;
   logic [OW-1:0] out_cnt_ff;

   logic [TW-1:0] mem [pswd_pkg::SLOTS];

   logic [EW-1:0] sel_e;
   logic [PW-1:0] sel_head;
   logic [CW-1:0] sel_count, n_scan;
   logic          mem_we, mem_re, keep;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [TW-1:0] mem_wdata, age;

   assign status.is_failure = fail_ff;
   assign status.scan_last  = (int'(idx_ff) == E - 1);
   assign status.prune_done = (rem_ff == '0) && !rdpend_ff;

   // entry choice: matching source, else first free, else stalest
   always_comb begin
      if (hit_ff)       sel_e = hit_idx_ff;
      else if (free_ff) sel_e = free_idx_ff;
      else              sel_e = min_idx_ff;
      sel_head  = hit_ff ? head_ff[sel_e]  : '0;
      sel_count = hit_ff ? count_ff[sel_e] : '0;
      // the new time takes one slot; the rest of the ring is rescanned
      n_scan = (int'(sel_count) == pswd_pkg::TIMES_PER_SOURCE) ?
               CW'(pswd_pkg::TIMES_PER_SOURCE - 1) : sel_count;
   end

   assign age  = (rdata_ff <= now_ff) ? (now_ff - rdata_ff) : '0;
   assign keep = rdpend_ff && (age <= win_ff);

   // newest first: the write pointer never passes the read pointer
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pswd_pkg::slot_of(ent_ff, wp_ff);
      mem_wdata = rdata_ff;
      if (cmd.pick) begin
         mem_we    = 1'b1;
         mem_waddr = pswd_pkg::slot_of(sel_e, sel_head);
         mem_wdata = now_ff;
      end else if (cmd.prune && keep) begin
         mem_we = 1'b1;
      end
      mem_re    = cmd.prune && (rem_ff != '0);
      mem_raddr = pswd_pkg::slot_of(ent_ff, rp_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= pswd_pkg::THRESHOLD_RESET;
         win_ff <= pswd_pkg::WINDOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            pswd_pkg::CSR_THRESHOLD: thr_ff <= csr_write_data[pswd_pkg::THR_W-1:0];
            pswd_pkg::CSR_WINDOW:    win_ff <= csr_write_data[TW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rdpend_ff <= 1'b0;
         rem_ff    <= '0;
         for (int i = 0; i < E; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (cmd.pick) begin
            rem_ff    <= n_scan;
            rdpend_ff <= 1'b0;
         end else if (cmd.prune) begin
            rdpend_ff <= mem_re;
            if (mem_re) rem_ff <= CW'(rem_ff - 1'b1);
         end
         if (cmd.commit) begin
            valid_ff[ent_ff] <= 1'b1;
            head_ff[ent_ff]  <= pswd_pkg::pos_inc(hd_ff);
            count_ff[ent_ff] <= k_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff      <= req_source_address;
         now_ff       <= req_event_time;
         fail_ff      <= req_is_failure;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         res_alarm_ff <= 1'b0;
         res_cnt_ff   <= '0;
         res_ev_ff    <= 1'b0;
      end
      if (cmd.search) begin
         if (!status.scan_last) idx_ff <= EW'(idx_ff + 1'b1);
         if (valid_ff[idx_ff] && key_ff[idx_ff] == addr_ff && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         if (!valid_ff[idx_ff] && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (idx_ff == '0 || last_ff[idx_ff] < min_t_ff) begin
            min_idx_ff <= idx_ff;
            min_t_ff   <= last_ff[idx_ff];
         end
      end
      if (cmd.pick) begin
         ent_ff <= sel_e;
         ev_ff  <= !hit_ff && !free_ff;
         hd_ff  <= sel_head;
         rp_ff  <= pswd_pkg::pos_dec(sel_head);
         wp_ff  <= pswd_pkg::pos_dec(sel_head);
         k_ff   <= CW'(1);
      end
      if (cmd.prune) begin
         if (mem_re) rp_ff <= pswd_pkg::pos_dec(rp_ff);
         if (keep) begin
            wp_ff <= pswd_pkg::pos_dec(wp_ff);
            k_ff  <= CW'(k_ff + 1'b1);
         end
      end
      if (cmd.commit) begin
         key_ff[ent_ff]  <= addr_ff;
         last_ff[ent_ff] <= now_ff;
         res_alarm_ff    <= (int'(k_ff) >= int'(thr_ff));
         res_cnt_ff      <= (int'(k_ff) > 31) ? OW'(31) : OW'(k_ff);
         res_ev_ff       <= ev_ff;
      end
      if (cmd.out_load) begin
         out_alarm_ff <= res_alarm_ff;
         out_cnt_ff   <= res_cnt_ff;
         out_ev_ff    <= res_ev_ff;
      end
   end

   assign rsp_alarm          = out_alarm_ff;
   assign rsp_retained_count = out_cnt_ff;
   assign rsp_entry_evicted  = out_ev_ff;

endmodule

@@ rtl/core/per_source_failure_window_detector.sv @@
// Top level of the per-source failure window detector.
// Instantiates pswd_ctrl and pswd_datapath; uses pswd_pkg.
//
// Usage:
//  - req_ channel: one beat per login event (source address, time, failure
//    flag), taken when req_valid is high and req_stall is low.
//  - rsp_ channel: one beat per event (alarm, retained count, eviction flag).
//  - csr_ port: write attempt_threshold (index 0) or window_seconds
//    (index 1) while the block is idle.
// Sequence:
//  - A non-failure beat goes from S_WAIT straight to S_OUT, skipping the table.
//  - A failure passes S_WAIT, S_SEARCH, S_PICK, S_PRUNE and S_COMMIT before
//    S_OUT: the search visits the table entries one after another, and the
//    prune reads the stored times one after another, since the time memory
//    has a single read and a single write port.
//  - req_stall is low only while no event is in progress, so the next beat
//    can be taken in the same cycle that rsp_valid rises; it may be taken
//    while the previous response still waits.
// Reset: clears the table valid bits, ring pointers and counts, and loads
//  threshold 5 and window 300. No clearing pass is needed.
// Stall: while rsp_stall is high the response beat holds; a finished
//  event waits for the output register before the block takes a new one.
module per_source_failure_window_detector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic                           csr_index,
   input  logic [pswd_pkg::CFG_W-1:0]     csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [31:0]                    req_source_address,
   input  logic [31:0]                    req_event_time,
   input  logic                           req_is_failure,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_alarm,
   output logic [pswd_pkg::CNT_OUT_W-1:0] rsp_retained_count,
   output logic                           rsp_entry_evicted
);

   pswd_pkg::ctrl_cmd_type  cmd;
   pswd_pkg::dp_status_type status;

   // sequence the steps and own both handshakes
   pswd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the table, the times and the response fields
   pswd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_source_address (req_source_address),
      .req_event_time     (req_event_time),
      .req_is_failure     (req_is_failure),
      .cmd                (cmd),
      .status             (status),
      .rsp_alarm          (rsp_alarm),
      .rsp_retained_count (rsp_retained_count),
      .rsp_entry_evicted  (rsp_entry_evicted)
   );

endmodule

@@ rtl/core/pswd_checker.sv @@
// Port-level checks for the detector, bound to the top level.
// Depends on pswd_pkg and per_source_failure_window_detector.
module pswd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_alarm,
   input logic [pswd_pkg::CNT_OUT_W-1:0] rsp_retained_count,
   input logic                           rsp_entry_evicted
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_retained_count) && $stable(rsp_alarm)
                                 && $stable(rsp_entry_evicted))
      else $error("stalled response changed");

   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_evicted |-> rsp_retained_count != '0)
      else $error("eviction reported without a retained time");

   a_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind per_source_failure_window_detector pswd_checker u_pswd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_alarm          (rsp_alarm),
   .rsp_retained_count (rsp_retained_count),
   .rsp_entry_evicted  (rsp_entry_evicted)
);

@@ verif/tb.sv @@
// Testbench for per_source_failure_window_detector: directed and random login
// events, predicted by a scoreboard class. Depends on pswd_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      logic       alarm;
      logic [4:0] count;
      logic       evicted;
   } verdict_type;

   // Scoreboard: keeps its own source table and checks response beats in order.
   class failure_scoreboard;
      bit [31:0]   keys[pswd_pkg::SOURCE_ENTRIES];
      bit          used[pswd_pkg::SOURCE_ENTRIES];
      bit [31:0]   times[pswd_pkg::SOURCE_ENTRIES][pswd_pkg::TIMES_PER_SOURCE];
      int          head[pswd_pkg::SOURCE_ENTRIES];
      int          fill[pswd_pkg::SOURCE_ENTRIES];
      bit [4:0]    threshold;
      bit [31:0]   window;
      verdict_type pending[$];
      int          errors;

      function void clear();
         for (int e = 0; e < pswd_pkg::SOURCE_ENTRIES; e++) begin
            used[e] = 0; head[e] = 0; fill[e] = 0;
         end
         threshold = pswd_pkg::THRESHOLD_RESET;
         window = pswd_pkg::WINDOW_RESET;
         pending.delete();
         errors = 0;
      endfunction

      function bit [31:0] newest(int e);
         if (fill[e] == 0) return 0;
         return times[e][(head[e] + pswd_pkg::TIMES_PER_SOURCE - 1) %
                         pswd_pkg::TIMES_PER_SOURCE];
      endfunction

      // Note an accepted event and queue the response it must produce.
      function void note_event(bit [31:0] addr, bit [31:0] now, bit fail);
         verdict_type v;
         bit [31:0]   kept[$];
         bit [31:0]   t, best_t;
         int          e, n, oldest, best;
         v = '0;
         if (fail) begin
            e = -1;
            for (int i = 0; i < pswd_pkg::SOURCE_ENTRIES; i++)
               if (e < 0 && used[i] && keys[i] == addr) e = i;
            if (e < 0) begin
               for (int i = 0; i < pswd_pkg::SOURCE_ENTRIES; i++)
                  if (e < 0 && !used[i]) e = i;
               if (e < 0) begin
                  best = 0; best_t = newest(0);
                  for (int i = 1; i < pswd_pkg::SOURCE_ENTRIES; i++)
                     if (newest(i) < best_t) begin best = i; best_t = newest(i); end
                  e = best;
                  v.evicted = 1;
               end
               used[e] = 1; keys[e] = addr; head[e] = 0; fill[e] = 0;
            end
            times[e][head[e]] = now;
            head[e] = (head[e] + 1) % pswd_pkg::TIMES_PER_SOURCE;
            n = (fill[e] < pswd_pkg::TIMES_PER_SOURCE) ? fill[e] + 1 : fill[e];
            oldest = (head[e] + pswd_pkg::TIMES_PER_SOURCE - n) %
                     pswd_pkg::TIMES_PER_SOURCE;
            for (int i = 0; i < n; i++) begin
               t = times[e][(oldest + i) % pswd_pkg::TIMES_PER_SOURCE];
               if (((t <= now) ? now - t : 32'd0) <= window) kept = {kept, t};
            end
            oldest = (head[e] + pswd_pkg::TIMES_PER_SOURCE - kept.size()) %
                     pswd_pkg::TIMES_PER_SOURCE;
            foreach (kept[i])
               times[e][(oldest + i) % pswd_pkg::TIMES_PER_SOURCE] = kept[i];
            fill[e] = kept.size();
            v.count = (fill[e] > 31) ? 5'd31 : 5'(fill[e]);
            v.alarm = (fill[e] >= threshold);
         end
         pending = {pending, v};
      endfunction

      function void check_response(verdict_type got);
         verdict_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response beat %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.alarm !== want.alarm) begin
            $display("%0t: alarm expected %0b actual %0b", $time, want.alarm, got.alarm);
            errors++;
         end
         if (got.count !== want.count) begin
            $display("%0t: retained_count expected %0d actual %0d", $time,
                     want.count, got.count);
            errors++;
         end
         if (got.evicted !== want.evicted) begin
            $display("%0t: entry_evicted expected %0b actual %0b", $time,
                     want.evicted, got.evicted);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic        csr_index = pswd_pkg::CSR_THRESHOLD;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_source_address = '0;
   logic [31:0] req_event_time = '0;
   logic        req_is_failure = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_alarm;
   logic [4:0]  rsp_retained_count;
   logic        rsp_entry_evicted;

   per_source_failure_window_detector dut (.*);

   failure_scoreboard board = new();
   int  cycles = 0;
   int  stall_mode = 0;
   bit  [31:0] clock_now = 1000;
   bit  [31:0] pool[8];

   initial forever #1 clock = ~clock;

   // Run watchdog: ~1400 events plus stalls and gaps fit far below the limit; past it the run ends as a mismatch.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Check every response beat at the rising edge where it is taken.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response({rsp_alarm, rsp_retained_count, rsp_entry_evicted});

   // Receiver stall pattern: drift between no stall, light and heavy stalling.
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Present one event and hold it until the block takes the beat. Valid
   // stays high afterwards so the next beat can follow; idle_gap drops it.
   task automatic send_event(bit [31:0] addr, bit [31:0] now, bit fail);
      req_valid <= 1;
      req_source_address <= addr;
      req_event_time <= now;
      req_is_failure <= fail;
      do @(posedge clock); while (req_stall);
      board.note_event(addr, now, fail);
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 0;
      repeat (n) @(negedge clock);
   endtask

   // Drain all responses, then let the block settle before a register write.
   task automatic drain();
      idle_gap(1);
      while (board.pending.size() != 0) @(negedge clock);
      idle_gap(50);
   endtask

   task automatic write_reg(logic idx, bit [31:0] value);
      drain();
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 0;
      if (idx == pswd_pkg::CSR_THRESHOLD) board.threshold = value[4:0];
      else board.window = value;
   endtask

   // Random phase: bursts of events over a small pool of sources so that
   // rings fill, windows expire and the table overflows.
   task automatic random_phase(int total);
      int burst;
      bit [31:0] addr;
      for (int i = 0; i < 8; i++) pool[i] = $urandom();
      for (int done = 0; done < total;) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && done < total; b++) begin
            case ($urandom_range(0, 9))
               0: addr = $urandom();
               1: addr = 32'(b);
               default: addr = pool[$urandom_range(0, 7)] + $urandom_range(0, 20);
            endcase
            case ($urandom_range(0, 9))
               0: clock_now = clock_now - $urandom_range(0, 50);
               1: clock_now = $urandom();
               default: clock_now = clock_now + $urandom_range(0, 40);
            endcase
            send_event(addr, clock_now, $urandom_range(0, 5) != 0);
            done++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 60));
      end
   endtask

   initial begin
      board.clear();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: non-failure, field extremes, backwards time, full ring, eviction.
      send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_event(32'h0, 32'h0, 1);
      send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send_event(32'h0, 32'd100, 1);
      send_event(32'h0, 32'd50, 1);
      send_event(32'h0, 32'd400, 1);
      send_event(32'h0, 32'd401, 1);
      for (int i = 0; i < 17; i++) send_event(32'hA5A5_5A5A, 32'd500, 1);
      for (int i = 0; i < 15; i++) send_event(32'h100 + i, 32'd600 + i, 1);

      write_reg(pswd_pkg::CSR_THRESHOLD, 0);
      write_reg(pswd_pkg::CSR_WINDOW, 0);
      random_phase(250);
      write_reg(pswd_pkg::CSR_THRESHOLD, 16);
      write_reg(pswd_pkg::CSR_WINDOW, 32'hFFFF_FFFF);
      random_phase(250);
      write_reg(pswd_pkg::CSR_THRESHOLD, 31);
      random_phase(150);
      write_reg(pswd_pkg::CSR_THRESHOLD, 3);
      write_reg(pswd_pkg::CSR_WINDOW, 60);
      random_phase(350);
      write_reg(pswd_pkg::CSR_THRESHOLD, 5);
      write_reg(pswd_pkg::CSR_WINDOW, 300);
      random_phase(350);

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
